### hdl/pbvx_pkg.sv
// Shared types, constants and the field-to-slot lookup for the varint field extractor.
package pbvx_pkg;

  localparam int MAX_MESSAGE_BYTES_DEF = 65535;
  localparam int NUM_SLOTS             = 21;
  localparam int SLOT_W                = 5;
  localparam int FIELD_W               = 32;
  localparam int VALUE_W               = 32;

  // Result kinds
  localparam logic KIND_FIELD = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] field_number;
    logic               known;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic               ok;
    logic               last;
  } result_t;

  // Up to two results per input beat; b only ever follows a
  typedef struct packed {
    logic    push_a;
    logic    push_b;
    result_t a;
    result_t b;
  } push_t;

  typedef struct packed {
    logic              known;
    logic [SLOT_W-1:0] slot;
  } slot_hit_t;

  localparam logic [FIELD_W-1:0] SLOT_MAP [NUM_SLOTS] = '{
    32'd16, 32'd18, 32'd19, 32'd20, 32'd21, 32'd23, 32'd24, 32'd25, 32'd29, 32'd30, 32'd31,
    32'd34, 32'd36, 32'd37, 32'd38, 32'd39, 32'd40, 32'd48, 32'd50, 32'd51, 32'd52
  };

  function automatic slot_hit_t slot_lookup(input logic [FIELD_W-1:0] fnum);
    slot_hit_t hit;
    hit = '0;
    // descending so the lowest matching index wins
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (SLOT_MAP[s] == fnum) begin
        hit.known = 1'b1;
        hit.slot  = SLOT_W'(s);
      end
    end
    return hit;
  endfunction

endpackage

### hdl/pbvx_decode.sv
// Input register and per-byte wire-format decoder with its running message state.
module pbvx_decode #(
  parameter int MAX_MESSAGE_BYTES = pbvx_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  input  logic             space_ok,
  output pbvx_pkg::push_t  push
);

  localparam int ACC_W  = 35;
  localparam int SKIP_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [ACC_W-1:0]  MAX_ACC  = ACC_W'(MAX_MESSAGE_BYTES);
  localparam logic [SKIP_W-1:0] MAX_SKIP = SKIP_W'(MAX_MESSAGE_BYTES);

  localparam logic [1:0] PH_TAG   = 2'd0;
  localparam logic [1:0] PH_VALUE = 2'd1;
  localparam logic [1:0] PH_LEN   = 2'd2;
  localparam logic [1:0] PH_SKIP  = 2'd3;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_I64    = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_I32    = 3'd5;

  // input register
  logic        in_vld_r;
  logic [7:0]  data_r;
  logic        last_r;
  logic        fire;

  // message state
  logic [1:0]                     phase_r, phase_nxt;
  logic [ACC_W-1:0]               acc_r, acc_nxt, acc_upd, acc_sh;
  logic [3:0]                     vb_r, vb_nxt;
  logic [pbvx_pkg::FIELD_W-1:0]   field_r, field_nxt;
  logic [SKIP_W-1:0]              skip_r, skip_nxt;
  logic                           failed_r, failed_nxt;

  logic [6:0]  pay;
  logic        lost;
  logic        fld_emit;
  logic        end_emit;
  logic        end_ok;
  pbvx_pkg::slot_hit_t hit;
  pbvx_pkg::result_t   fld_res, end_res;

  assign fire     = in_vld_r & space_ok;
  assign in_stall = in_vld_r & ~space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign pay = data_r[6:0];

  always_comb begin
    case (vb_r)
      4'd0:    acc_sh = ACC_W'(pay);
      4'd1:    acc_sh = ACC_W'(pay) << 7;
      4'd2:    acc_sh = ACC_W'(pay) << 14;
      4'd3:    acc_sh = ACC_W'(pay) << 21;
      4'd4:    acc_sh = ACC_W'(pay) << 28;
      default: acc_sh = '0;
    endcase
  end

  // bits beyond the kept 35 but within 64 saturate a length
  always_comb begin
    if (vb_r < 4'd9)       lost = (pay != 7'd0);
    else if (vb_r == 4'd9) lost = pay[0];
    else                   lost = 1'b0;
  end

  always_comb begin
    if (vb_r < 4'd5)                       acc_upd = acc_r | acc_sh;
    else if (phase_r == PH_LEN && lost)    acc_upd = '1;
    else                                   acc_upd = acc_r;
  end

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    vb_nxt     = vb_r;
    field_nxt  = field_r;
    skip_nxt   = skip_r;
    failed_nxt = failed_r;
    fld_emit   = 1'b0;
    end_emit   = 1'b0;
    end_ok     = 1'b0;
    if (fire) begin
      if (!failed_r) begin
        if (phase_r == PH_SKIP) begin
          if (skip_r != '0) skip_nxt = skip_r - SKIP_W'(1);
          if (skip_nxt == '0) phase_nxt = PH_TAG;
        end else begin
          acc_nxt = acc_upd;
          vb_nxt  = vb_r + 4'd1;
          if (data_r[7]) begin
            if (vb_r >= 4'd9) failed_nxt = 1'b1;
          end else begin
            acc_nxt = '0;
            vb_nxt  = 4'd0;
            case (phase_r)
              PH_TAG: begin
                field_nxt = acc_upd[ACC_W-1:3];
                case (acc_upd[2:0])
                  WT_VARINT: phase_nxt = PH_VALUE;
                  WT_I64: begin
                    skip_nxt  = SKIP_W'(8);
                    phase_nxt = PH_SKIP;
                  end
                  WT_I32: begin
                    skip_nxt  = SKIP_W'(4);
                    phase_nxt = PH_SKIP;
                  end
                  WT_LEN:  phase_nxt  = PH_LEN;
                  default: failed_nxt = 1'b1;
                endcase
              end
              PH_VALUE: begin
                fld_emit  = 1'b1;
                phase_nxt = PH_TAG;
              end
              default: begin
                if (acc_upd == '0) begin
                  phase_nxt = PH_TAG;
                end else begin
                  skip_nxt  = (acc_upd > MAX_ACC) ? MAX_SKIP : acc_upd[SKIP_W-1:0];
                  phase_nxt = PH_SKIP;
                end
              end
            endcase
          end
        end
      end
      if (last_r) begin
        end_emit = 1'b1;
        end_ok   = ~(failed_nxt | (phase_nxt != PH_TAG) | (vb_nxt != 4'd0));
        // fresh state for the next message
        phase_nxt  = PH_TAG;
        acc_nxt    = '0;
        vb_nxt     = 4'd0;
        field_nxt  = '0;
        skip_nxt   = '0;
        failed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TAG;
      acc_r    <= '0;
      vb_r     <= 4'd0;
      field_r  <= '0;
      skip_r   <= '0;
      failed_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      vb_r     <= vb_nxt;
      field_r  <= field_nxt;
      skip_r   <= skip_nxt;
      failed_r <= failed_nxt;
    end
  end

  assign hit = pbvx_pkg::slot_lookup(field_r);

  always_comb begin
    fld_res              = '0;
    fld_res.kind         = pbvx_pkg::KIND_FIELD;
    fld_res.field_number = field_r;
    fld_res.known        = hit.known;
    fld_res.slot         = hit.slot;
    fld_res.value        = acc_upd[pbvx_pkg::VALUE_W-1:0];
    fld_res.last         = ~last_r;
    end_res              = '0;
    end_res.kind         = pbvx_pkg::KIND_END;
    end_res.ok           = end_ok;
    end_res.last         = 1'b1;
  end

  always_comb begin
    push.push_a = fld_emit | end_emit;
    push.push_b = fld_emit & end_emit;
    push.a      = fld_emit ? fld_res : end_res;
    push.b      = end_res;
  end

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_r != '0)
    else $error("skip phase with nothing left to skip");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last_r |=> phase_r == PH_TAG && vb_r == 4'd0 && !failed_r)
    else $error("state not cleared after end of message");

  a_no_field_after_fail: assert property (@(posedge clk) disable iff (!rst_n)
    push.push_a && push.a.kind == pbvx_pkg::KIND_FIELD |-> !failed_r)
    else $error("field result from a failed message");

endmodule

### hdl/pbvx_rfifo.sv
// Four-entry result queue taking up to two results a cycle and giving one beat a cycle unless stalled.
module pbvx_rfifo (
  input  logic              clk,
  input  logic              rst_n,
  input  pbvx_pkg::push_t   push,
  output logic              space_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output pbvx_pkg::result_t head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pbvx_pkg::result_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] n_push;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid & ~out_stall;
  assign space_ok  = (count_r <= CNT_W'(DEPTH - 2));
  assign head      = mem_r[rd_ptr_r];
  assign n_push    = CNT_W'(push.push_a) + CNT_W'(push.push_b);

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + n_push - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.push_a) mem_r[wr_ptr_r] <= push.a;
    if (push.push_b) mem_r[wr_ptr_r + PTR_W'(1)] <= push.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.push_a |-> count_r <= CNT_W'(DEPTH - 2))
    else $error("result pushed without room");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.push_b |-> push.push_a && push.b.kind == pbvx_pkg::KIND_END)
    else $error("second result without first, or not an end result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

### hdl/protobuf_varint_field_extractor_core.sv
// Top level of the protobuf varint field extractor: byte in, field and end results out.
// Path: a byte accepted into the input register is decoded from it once the result
//   queue has room; its results go into that queue and are presented from its head.
// Throughput: one byte per cycle while the result queue has room for two results;
//   a byte giving field and end results adds one beat, absorbed by the 4-entry queue.
// Reset: synchronous active-low rst_n clears handshake and message state; a fresh
//   message starts expecting a tag. No clearing pass is needed.
module protobuf_varint_field_extractor_core #(
  parameter int MAX_MESSAGE_BYTES = pbvx_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // byte input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_last_byte,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_kind,
  output logic [pbvx_pkg::FIELD_W-1:0]    out_field_number,
  output logic                            out_known,
  output logic [pbvx_pkg::SLOT_W-1:0]     out_slot,
  output logic [pbvx_pkg::VALUE_W-1:0]    out_value,
  output logic                            out_ok,
  output logic                            out_last
);

  // Two parts: the decoder holds the input register and all message state and
  // works one byte per cycle; the queue decouples its 0..2 results per beat
  // from the one-beat-per-cycle output. The decoder only takes a byte from its
  // input register when the queue has room for two results.
  pbvx_pkg::push_t   push;
  pbvx_pkg::result_t head;
  logic              space_ok;

  pbvx_decode #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .space_ok     (space_ok),
    .push         (push)
  );

  pbvx_rfifo u_rfifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // queue head drives the result beat directly; it holds while stalled
  assign out_kind         = head.kind;
  assign out_field_number = head.field_number;
  assign out_known        = head.known;
  assign out_slot         = head.slot;
  assign out_value        = head.value;
  assign out_ok           = head.ok;
  assign out_last         = head.last;

endmodule

### dv/protobuf_varint_field_extractor_core_tb.sv
// Self-checking testbench for the protobuf varint field extractor core.
module protobuf_varint_field_extractor_core_tb;

  localparam int MSG_LIMIT    = pbvx_pkg::MAX_MESSAGE_BYTES_DEF;
  localparam int QUIET_LIMIT  = 1000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 20;    // settle time after the last result
  localparam int RANDOM_BYTES = 1060;

  // Wire types of the protobuf encoding
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_SGROUP  = 3'd3;
  localparam logic [2:0] WT_EGROUP  = 3'd4;
  localparam logic [2:0] WT_FIXED32 = 3'd5;
  localparam logic [2:0] WT_RSVD6   = 3'd6;
  localparam logic [2:0] WT_RSVD7   = 3'd7;

  localparam logic [2:0] BAD_WIRES [4] = '{WT_SGROUP, WT_EGROUP, WT_RSVD6, WT_RSVD7};

  // Field numbers with a slot, slot index = position in this list
  localparam int unsigned KNOWN_FIELDS [21] = '{
    16, 18, 19, 20, 21, 23, 24, 25, 29, 30, 31, 34, 36, 37, 38, 39, 40, 48, 50, 51, 52
  };

  typedef enum logic [1:0] {AWAIT_TAG, AWAIT_VALUE, AWAIT_LEN, SKIPPING} parse_state_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     in_data_byte;
  logic                           in_last_byte;
  logic                           out_valid;
  logic                           out_stall;
  logic                           out_kind;
  logic [pbvx_pkg::FIELD_W-1:0]   out_field_number;
  logic                           out_known;
  logic [pbvx_pkg::SLOT_W-1:0]    out_slot;
  logic [pbvx_pkg::VALUE_W-1:0]   out_value;
  logic                           out_ok;
  logic                           out_last;

  protobuf_varint_field_extractor_core #(
    .MAX_MESSAGE_BYTES(MSG_LIMIT)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_field_number (out_field_number),
    .out_known        (out_known),
    .out_slot         (out_slot),
    .out_value        (out_value),
    .out_ok           (out_ok),
    .out_last         (out_last)
  );

  // Decoder shadow state, advanced once per accepted byte
  parse_state_t  pstate;
  logic [34:0]   acc;
  logic [3:0]    acc_bytes;
  logic [31:0]   cur_field;
  logic [2:0]    cur_wire;
  int unsigned   bytes_to_skip;
  bit            msg_failed;

  pbvx_pkg::result_t pending_results [$];  // decoded results not yet seen at the output
  logic [7:0]        msg_bytes [$];        // message under construction
  int                mismatches;
  bit                send_quiet;           // sender back-to-back when set
  bit                recv_quiet;           // receiver never stalls when set

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------
  task automatic clear_decoder();
    pstate        = AWAIT_TAG;
    acc           = '0;
    acc_bytes     = '0;
    cur_field     = '0;
    cur_wire      = '0;
    bytes_to_skip = 0;
    msg_failed    = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eom);
    pbvx_pkg::result_t r;
    logic [34:0]       v;
    int                k;
    bit                lost;
    if (!msg_failed) begin
      if (pstate == SKIPPING) begin
        if (bytes_to_skip > 0) bytes_to_skip--;
        if (bytes_to_skip == 0) pstate = AWAIT_TAG;
      end else begin
        k = acc_bytes;
        if (k < 5) begin
          acc = acc | (35'(b[6:0]) << (7 * k));
        end else if (pstate == AWAIT_LEN) begin
          // length bits beyond the kept 35 but within 64 saturate the length
          lost = (k < 9) ? (b[6:0] != 7'd0) : ((k == 9) ? b[0] : 1'b0);
          if (lost) acc = '1;
        end
        acc_bytes = 4'(k + 1);
        if (b[7]) begin
          if (k + 1 >= 10) msg_failed = 1'b1;  // varint longer than ten bytes
        end else begin
          v         = acc;
          acc       = '0;
          acc_bytes = '0;
          case (pstate)
            AWAIT_TAG: begin
              cur_field = v[34:3];
              cur_wire  = v[2:0];
              case (cur_wire)
                WT_VARINT:  pstate = AWAIT_VALUE;
                WT_FIXED64: begin bytes_to_skip = 8; pstate = SKIPPING; end
                WT_FIXED32: begin bytes_to_skip = 4; pstate = SKIPPING; end
                WT_LEN:     pstate = AWAIT_LEN;
                default:    msg_failed = 1'b1;
              endcase
            end
            AWAIT_VALUE: begin
              r              = '0;
              r.kind         = pbvx_pkg::KIND_FIELD;
              r.field_number = cur_field;
              r.value        = v[31:0];
              r.last         = !eom;
              for (int s = 0; s < 21; s++) begin
                if (!r.known && KNOWN_FIELDS[s] == cur_field) begin
                  r.known = 1'b1;
                  r.slot  = s[pbvx_pkg::SLOT_W-1:0];
                end
              end
              pending_results.push_back(r);
              pstate = AWAIT_TAG;
            end
            default: begin
              // length prefix; zero skips nothing, long ones are capped
              if (v == '0) begin
                pstate = AWAIT_TAG;
              end else begin
                bytes_to_skip = (v > 35'(MSG_LIMIT)) ? MSG_LIMIT : int'(v);
                pstate        = SKIPPING;
              end
            end
          endcase
        end
      end
    end
    if (eom) begin
      // ending inside any item fails the message
      if (pstate != AWAIT_TAG || acc_bytes != 0) msg_failed = 1'b1;
      r      = '0;
      r.kind = pbvx_pkg::KIND_END;
      r.ok   = !msg_failed;
      r.last = 1'b1;
      pending_results.push_back(r);
      clear_decoder();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Handshake drivers
  // ---------------------------------------------------------------------------
  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // Outputs are sampled at the falling edge, where everything has settled
  // to the values the next rising edge will see.
  task automatic send_beat(input logic [7:0] data, input logic eom);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= eom;
    @(negedge clk);
    while (in_stall !== 1'b0) @(negedge clk);
    @(posedge clk);
    decode_byte(data, eom);
  endtask

  // Hold the sender off until every predicted result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_message(input bit drain_inside);
    int cut;
    cut = drain_inside ? $urandom_range(0, msg_bytes.size() - 1) : -1;
    for (int i = 0; i < msg_bytes.size(); i++) begin
      if (i == cut) wait_drained();
      send_beat(msg_bytes[i], i == msg_bytes.size() - 1);
    end
    msg_bytes.delete();
  endtask

  // Receiver: a fresh stall draw before each result beat
  initial begin
    int gap;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      gap = draw_gap(recv_quiet);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (!(out_valid === 1'b1 && out_stall === 1'b0)) @(negedge clk);
      @(posedge clk);
    end
  end

  // Result checker: each output beat against the oldest prediction
  task automatic check_result();
    pbvx_pkg::result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result beat with nothing pending, field_number",
                      out_field_number, '0);
      return;
    end
    want = pending_results.pop_front();
    check_field("kind",         32'(out_kind),     32'(want.kind));
    check_field("field_number", out_field_number,  want.field_number);
    check_field("known",        32'(out_known),    32'(want.known));
    check_field("slot",         32'(out_slot),     32'(want.slot));
    check_field("value",        out_value,         want.value);
    check_field("ok",           32'(out_ok),       32'(want.ok));
    check_field("last",         32'(out_last),     32'(want.last));
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) check_result();
    end
  end

  // Watchdog: too long without a beat on either channel means a hang
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(negedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Message construction
  // ---------------------------------------------------------------------------
  function automatic int varint_len(input logic [69:0] val);
    int n;
    n = 1;
    for (int i = 1; i < 10; i++)
      if ((val >> (7 * i)) != '0) n = i + 1;
    return n;
  endfunction

  // nb > minimal length gives a padded, non-minimal encoding
  task automatic add_varint(input logic [69:0] val, input int nb);
    logic [7:0] b;
    int         n;
    n = varint_len(val);
    if (nb > n) n = nb;
    for (int i = 0; i < n; i++) begin
      b = {1'b0, val[7*i +: 7]};
      if (i < n - 1) b[7] = 1'b1;
      msg_bytes.push_back(b);
    end
  endtask

  task automatic add_tag(input logic [66:0] fnum, input logic [2:0] wire_t, input int nb);
    add_varint({fnum, wire_t}, nb);
  endtask

  task automatic add_random_bytes(input int count);
    repeat (count) msg_bytes.push_back(8'($urandom));
  endtask

  function automatic int varint_pad();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
  endfunction

  // Mostly mapped fields, then small, 32-bit and oversized field numbers
  function automatic logic [66:0] rand_field();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 67'(KNOWN_FIELDS[$urandom_range(0, 20)]);
      5, 6:          return 67'($urandom_range(0, 60));
      7:             return 67'($urandom);
      default:       return {3'($urandom_range(0, 7)), $urandom, $urandom};
    endcase
  endfunction

  function automatic logic [69:0] rand_wide();
    logic [95:0] raw;
    int          nbits;
    raw   = {$urandom, $urandom, $urandom};
    nbits = $urandom_range(0, 70);
    return raw[69:0] & ((70'd1 << nbits) - 70'd1);
  endfunction

  task automatic add_random_item();
    int len;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        add_tag(rand_field(), WT_VARINT, varint_pad());
        add_varint(rand_wide(), varint_pad());
      end
      5: begin
        add_tag(rand_field(), WT_FIXED64, varint_pad());
        add_random_bytes(8);
      end
      6: begin
        add_tag(rand_field(), WT_FIXED32, varint_pad());
        add_random_bytes(4);
      end
      7, 8: begin
        // short payloads mostly, an occasional long one
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 200) : $urandom_range(0, 12);
        add_tag(rand_field(), WT_LEN, varint_pad());
        add_varint(70'(len), varint_pad());
        add_random_bytes(len);
      end
      default: begin
        add_tag(rand_field(), WT_VARINT, varint_pad());
        add_varint(70'($urandom_range(0, 300)), varint_pad());
      end
    endcase
  endtask

  // Ten to thirteen bytes with continuation and a final byte, as a tag, a value or a length
  task automatic add_overlong_varint();
    case ($urandom_range(0, 2))
      0: ;
      1: add_tag(rand_field(), WT_VARINT, 0);
      default: add_tag(rand_field(), WT_LEN, 0);
    endcase
    repeat ($urandom_range(10, 13)) msg_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
    msg_bytes.push_back(8'($urandom_range(0, 127)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_varint_fields();
    send_quiet = 1'b1;
    recv_quiet = 1'b1;
    // field 16 = 0, then field 52 with all 35 kept bits set; the last byte
    // yields the field result and the end result together
    msg_bytes = {8'h80, 8'h01, 8'h00, 8'hA0, 8'h03, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
    send_message(1'b0);
  endtask

  task automatic test_skipped_items();
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    // fixed32, zero-length item, fixed64; drains once mid-message
    msg_bytes = {8'h0D, 8'h11, 8'h22, 8'h33, 8'h44, 8'h12, 8'h00,
                 8'h19, 8'hFF, 8'h80, 8'h7F, 8'h00, 8'h55, 8'hAA, 8'h01, 8'hFE};
    send_message(1'b1);
  endtask

  task automatic test_malformed_messages();
    // group wire type, then a byte that must be ignored
    msg_bytes = {8'h0B, 8'hFF};
    send_message(1'b0);
    // message ends inside a tag varint
    msg_bytes.push_back(8'h80);
    send_message(1'b0);
    // tag with ten continuation bytes
    repeat (10) msg_bytes.push_back(8'h80);
    send_message(1'b0);
    // length with bit 35 set saturates, message ends inside the skip
    msg_bytes = {8'h0A, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01};
    send_message(1'b0);
  endtask

  task automatic test_random_messages();
    int sent;
    int pick;
    int cut;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) begin
        send_quiet = ($urandom_range(0, 2) == 0);
        recv_quiet = ($urandom_range(0, 2) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick >= 95) begin
        add_random_bytes($urandom_range(1, 16));
      end else begin
        repeat ($urandom_range(1, 5)) add_random_item();
        if (pick >= 70 && pick < 78) begin
          // cut short at a random point
          cut = $urandom_range(1, msg_bytes.size() - 1);
          repeat (cut) void'(msg_bytes.pop_back());
        end else if (pick >= 78 && pick < 84) begin
          add_tag(rand_field(), BAD_WIRES[$urandom_range(0, 3)], varint_pad());
          repeat ($urandom_range(0, 2)) add_random_item();
        end else if (pick >= 84 && pick < 89) begin
          add_overlong_varint();
          repeat ($urandom_range(0, 2)) add_random_item();
        end else if (pick >= 89) begin
          // length too large for the rest of the message
          add_tag(rand_field(), WT_LEN, varint_pad());
          add_varint(rand_wide() | (70'd1 << $urandom_range(16, 69)), varint_pad());
          add_random_bytes($urandom_range(0, 6));
        end
      end
      sent += msg_bytes.size();
      send_message($urandom_range(0, 24) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_byte <= 1'b0;
    rst_n        <= 1'b0;
    mismatches   = 0;
    send_quiet   = 1'b0;
    recv_quiet   = 1'b0;
    clear_decoder();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_varint_fields();
    test_skipped_items();
    test_malformed_messages();
    wait_drained();
    test_random_messages();
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
hdl/pbvx_pkg.sv
hdl/pbvx_decode.sv
hdl/pbvx_rfifo.sv
hdl/protobuf_varint_field_extractor_core.sv
dv/protobuf_varint_field_extractor_core_tb.sv
